FILE: rtl/core/aps_pkg.sv
// Package for the armed PWM slew limiter: command codes, register indexes, reset defaults.
package aps_pkg;

  localparam int CMD_BITS = 3;
  localparam logic [CMD_BITS-1:0] CMD_TICK      = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_ARM       = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_DISARM    = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_SPIN      = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_SPIN_DOWN = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_CUTOFF    = 3'd5;

  localparam int CFG_ADDR_BITS = 2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_PWM_MIN   = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_PWM_MAX   = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SLEW_STEP = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_TIMEOUT   = 2'd3;

  localparam int DEF_WIDTH_BITS      = 12;
  localparam int DEF_TICK_COUNT_BITS = 16;
  localparam int DEF_POWER_FRAC_BITS = 10;

  localparam int RST_PWM_MIN   = 1000;
  localparam int RST_PWM_MAX   = 2000;
  localparam int RST_SLEW_STEP = 10;
  localparam int RST_TIMEOUT   = 50;

endpackage

FILE: rtl/core/armed_pwm_slew_limiter.sv
// Armed PWM slew limiter: command decode, spin mapping, timeout and slew update.
//
//   channel  | direction | tdata fields (lsb first)                 | tuser
//   in_      | slave     | command[2:0], power[PW+2:3] (signed)     | -
//   out_     | master    | pulse_width_us[WB-1:0], armed[WB]        | -
//   cfg_     | write     | cfg_addr selects register, cfg_wdata     | -
//
// One command per cycle sustained while the output is not stalled; each command is registered
// in the input register, then goes through decode, multiply and slew into the output register.
// All state (armed flag, target, current width, tick count) updates as the output register loads,
// so the next command sees it at once. Reset is synchronous; state starts disarmed at the
// default minimum width. A stalled output holds both stages; the input register refills
// in the same cycle the output is taken.
module armed_pwm_slew_limiter
  import aps_pkg::*;
#(
  parameter int WIDTH_BITS      = DEF_WIDTH_BITS,
  parameter int TICK_COUNT_BITS = DEF_TICK_COUNT_BITS,
  parameter int POWER_FRAC_BITS = DEF_POWER_FRAC_BITS,
  localparam int PW_BITS   = POWER_FRAC_BITS + 2,
  localparam int IN_BITS   = CMD_BITS + PW_BITS,
  localparam int IN_DW     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = WIDTH_BITS + 1,
  localparam int OUT_DW    = ((OUT_BITS + 7) / 8) * 8,
  localparam int CFG_DW    = (WIDTH_BITS > TICK_COUNT_BITS) ? WIDTH_BITS : TICK_COUNT_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DW-1:0]         in_tdata,   // command, power (signed), zero pad
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DW-1:0]        out_tdata,  // pulse_width_us, armed, zero pad
  input  logic                     cfg_wr_en,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DW-1:0]        cfg_wdata
);

  localparam int WB = WIDTH_BITS;
  localparam int TB = TICK_COUNT_BITS;
  localparam int FB = POWER_FRAC_BITS;
  localparam int PROD_BITS = WB + FB + 1;
  localparam int SW = WB + 2;
  localparam logic [FB:0]        FULL = (FB+1)'(1) << FB;
  localparam logic [PROD_BITS-1:0] HALF = PROD_BITS'(1) << (FB - 1);
  localparam logic [TB-1:0]      TICK_MAX = '1;
  localparam logic [WB-1:0]      RST_MIN_W = WB'(RST_PWM_MIN);

  // configuration registers
  logic [WB-1:0] pwm_min_r, pwm_max_r, slew_step_r;
  logic [TB-1:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_min_r   <= WB'(RST_PWM_MIN);
      pwm_max_r   <= WB'(RST_PWM_MAX);
      slew_step_r <= WB'(RST_SLEW_STEP);
      timeout_r   <= TB'(RST_TIMEOUT);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_PWM_MIN:   pwm_min_r   <= cfg_wdata[WB-1:0];
        REG_PWM_MAX:   pwm_max_r   <= cfg_wdata[WB-1:0];
        REG_SLEW_STEP: slew_step_r <= cfg_wdata[WB-1:0];
        REG_TIMEOUT:   timeout_r   <= cfg_wdata[TB-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic                s1_vld_r;
  logic [CMD_BITS-1:0] s1_cmd_r;
  logic [PW_BITS-1:0]  s1_pwr_r;
  logic                s1_adv;
  logic                in_acc;

  assign s1_adv    = s1_vld_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r <= in_tdata[CMD_BITS-1:0];
      s1_pwr_r <= in_tdata[CMD_BITS +: PW_BITS];
    end
  end

  // state
  logic          armed_r, armed_nxt;
  logic [WB-1:0] tgt_r, tgt_nxt;
  logic [WB-1:0] cur_r, cur_nxt;
  logic [TB-1:0] ticks_r, ticks_nxt;

  // effective band and spin target
  logic [WB-1:0]        eff_max;
  logic [WB-1:0]        range;
  logic [FB:0]          pmag, pclamp;
  logic [PROD_BITS-1:0] prod, prod_rnd;
  logic [WB-1:0]        spin_tgt;

  assign eff_max  = (pwm_max_r < pwm_min_r) ? pwm_min_r : pwm_max_r;
  assign range    = eff_max - pwm_min_r;
  assign pmag     = s1_pwr_r[PW_BITS-2:0];
  assign pclamp   = s1_pwr_r[PW_BITS-1] ? '0 : ((pmag > FULL) ? FULL : pmag);
  assign prod     = PROD_BITS'(range) * PROD_BITS'(pclamp);
  assign prod_rnd = prod + HALF;
  assign spin_tgt = pwm_min_r + prod_rnd[FB +: WB];

  // tick path: count, timeout, slew toward target, clamp to band
  logic [TB-1:0]        tick_cnt;
  logic [WB-1:0]        tick_tgt;
  logic signed [SW-1:0] cur_s, tgt_s, step_s, min_s, max_s, delta, slewed;
  logic [WB-1:0]        tick_cur;

  assign tick_cnt = (ticks_r < TICK_MAX) ? ticks_r + TB'(1) : ticks_r;
  assign tick_tgt = (tick_cnt > timeout_r) ? pwm_min_r : tgt_r;
  assign cur_s    = signed'({2'b00, cur_r});
  assign tgt_s    = signed'({2'b00, tick_tgt});
  assign step_s   = signed'({2'b00, slew_step_r});
  assign min_s    = signed'({2'b00, pwm_min_r});
  assign max_s    = signed'({2'b00, eff_max});
  assign delta    = tgt_s - cur_s;

  always_comb begin
    if (delta > step_s) begin
      slewed = cur_s + step_s;
    end else if (delta < -step_s) begin
      slewed = cur_s - step_s;
    end else begin
      slewed = tgt_s;
    end
    if (slewed < min_s) begin
      slewed = min_s;
    end
    if (slewed > max_s) begin
      slewed = max_s;
    end
  end

  assign tick_cur = slewed[WB-1:0];

  // command decode
  always_comb begin
    armed_nxt = armed_r;
    tgt_nxt   = tgt_r;
    cur_nxt   = cur_r;
    ticks_nxt = ticks_r;
    unique case (s1_cmd_r)
      CMD_TICK: begin
        if (armed_r) begin
          ticks_nxt = tick_cnt;
          tgt_nxt   = tick_tgt;
          cur_nxt   = tick_cur;
        end
      end
      CMD_ARM: begin
        if (!armed_r) begin
          armed_nxt = 1'b1;
          tgt_nxt   = pwm_min_r;
          cur_nxt   = pwm_min_r;
          ticks_nxt = '0;
        end
      end
      CMD_DISARM: begin
        if (armed_r) begin
          armed_nxt = 1'b0;
          tgt_nxt   = pwm_min_r;
          cur_nxt   = pwm_min_r;
          ticks_nxt = '0;
        end
      end
      CMD_SPIN: begin
        if (armed_r) begin
          tgt_nxt   = spin_tgt;
          ticks_nxt = '0;
        end
      end
      CMD_SPIN_DOWN: begin
        if (armed_r) begin
          tgt_nxt   = pwm_min_r;
          ticks_nxt = '0;
        end
      end
      CMD_CUTOFF: begin
        if (armed_r) begin
          tgt_nxt   = pwm_min_r;
          cur_nxt   = pwm_min_r;
          ticks_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      tgt_r   <= RST_MIN_W;
      cur_r   <= RST_MIN_W;
      ticks_r <= '0;
    end else if (s1_adv) begin
      armed_r <= armed_nxt;
      tgt_r   <= tgt_nxt;
      cur_r   <= cur_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  // output register
  logic                out_vld_r;
  logic [OUT_DW-1:0]   out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= OUT_DW'({armed_nxt, cur_nxt});
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // checks
  a_disarmed_settled: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> (cur_r == tgt_r))
    else $error("disarmed with current width apart from target");

  a_no_accept_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_adv) |-> !in_tready)
    else $error("input accepted while input register is held");

  a_spin_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && armed_r && (s1_cmd_r == CMD_SPIN || s1_cmd_r == CMD_SPIN_DOWN))
      |=> (ticks_r == '0))
    else $error("spin command left tick count set");

  a_output_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_data_r[WB-1:0] == cur_r && out_data_r[WB] == armed_r))
    else $error("output transaction differs from updated state");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for the armed PWM slew limiter: directed and random commands against a predictor.
module testbench;
  import aps_pkg::*;

  // Command codes the block decodes as no-ops
  localparam logic [CMD_BITS-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_BITS-1:0] CMD_RSVD_7 = 3'd7;

  localparam int FULL_POWER   = 1 << DEF_POWER_FRAC_BITS;
  localparam int HALF_LSB     = 1 << (DEF_POWER_FRAC_BITS - 1);
  localparam int STALL_LIMIT  = 5000;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_ITEMS  = 100;
  localparam int SAT_TICKS    = 120;

  typedef struct packed {
    logic        armed;
    logic [11:0] width;
  } pwm_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [15:0]              in_tdata = '0;   // command[2:0], power[14:3], pad[15]
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [15:0]              out_tdata;       // pulse_width_us[11:0], armed[12], pad[15:13]
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = REG_PWM_MIN;
  logic [15:0]              cfg_wdata = '0;

  // Predictor copy of the registers and state
  logic [11:0] pwm_min;
  logic [11:0] pwm_max;
  logic [11:0] slew_step;
  logic [15:0] timeout_ticks;
  logic        armed_q;
  logic [11:0] target_q;
  logic [11:0] current_q;
  logic [15:0] idle_ticks;

  pwm_result_t expected_results[$];
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  armed_pwm_slew_limiter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [11:0] band_top();
    return (pwm_max < pwm_min) ? pwm_min : pwm_max;
  endfunction

  // Map saturated power onto the band, round half up; restart the timeout
  function automatic void set_spin_target(int p);
    int span;
    span = int'(band_top()) - int'(pwm_min);
    if (p < 0) p = 0;
    if (p > FULL_POWER) p = FULL_POWER;
    target_q = 12'(int'(pwm_min) + ((span * p + HALF_LSB) >>> DEF_POWER_FRAC_BITS));
    idle_ticks = '0;
  endfunction

  function automatic pwm_result_t apply_command(logic [2:0] cmd, logic signed [11:0] power);
    pwm_result_t r;
    int cur;
    int delta;
    int step;
    case (cmd)
      CMD_TICK: if (armed_q) begin
        if (idle_ticks != '1) idle_ticks++;
        if (idle_ticks > timeout_ticks) target_q = pwm_min;
        cur = int'(current_q);
        step = int'(slew_step);
        delta = int'(target_q) - cur;
        if (delta > step) delta = step;
        if (delta < -step) delta = -step;
        cur += delta;
        if (cur < int'(pwm_min)) cur = int'(pwm_min);
        if (cur > int'(band_top())) cur = int'(band_top());
        current_q = 12'(cur);
      end
      CMD_ARM: if (!armed_q) begin
        target_q = pwm_min;
        current_q = pwm_min;
        armed_q = 1'b1;
        idle_ticks = '0;
      end
      CMD_DISARM: if (armed_q) begin
        target_q = pwm_min;
        current_q = pwm_min;
        armed_q = 1'b0;
        idle_ticks = '0;
      end
      CMD_SPIN: if (armed_q) begin
        set_spin_target(int'(power));
      end
      CMD_SPIN_DOWN: if (armed_q) begin
        set_spin_target(0);
      end
      CMD_CUTOFF: if (armed_q) begin
        set_spin_target(0);
        current_q = pwm_min;
      end
      default: begin
      end
    endcase
    r.armed = armed_q;
    r.width = current_q;
    return r;
  endfunction

  function automatic void report_failure(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
  endfunction

  task automatic apply_reset();
    pwm_min = 12'(RST_PWM_MIN);
    pwm_max = 12'(RST_PWM_MAX);
    slew_step = 12'(RST_SLEW_STEP);
    timeout_ticks = 16'(RST_TIMEOUT);
    armed_q = 1'b0;
    target_q = pwm_min;
    current_q = pwm_min;
    idle_ticks = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic send_cmd(logic [2:0] cmd, logic signed [11:0] power);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, power, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(apply_command(cmd, power));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [15:0] data);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_config(int min_us, int max_us, int step_us, int timeout);
    wait_drained();
    write_reg(REG_PWM_MIN, 16'(min_us));
    write_reg(REG_PWM_MAX, 16'(max_us));
    write_reg(REG_SLEW_STEP, 16'(step_us));
    write_reg(REG_TIMEOUT, 16'(timeout));
    cfg_wr_en <= 1'b0;
    pwm_min = 12'(min_us);
    pwm_max = 12'(max_us);
    slew_step = 12'(step_us);
    timeout_ticks = 16'(timeout);
  endtask

  task automatic test_directed_commands();
    // Everything but arm is dropped while disarmed
    send_cmd(CMD_TICK, 12'sd0);
    send_cmd(CMD_SPIN, 12'sd1024);
    send_cmd(CMD_SPIN_DOWN, 12'sd0);
    send_cmd(CMD_CUTOFF, 12'sd0);
    send_cmd(CMD_DISARM, 12'sd0);
    send_cmd(CMD_RSVD_6, 12'h7FF);
    send_cmd(CMD_ARM, 12'sd0);
    send_cmd(CMD_ARM, 12'sd0);
    send_cmd(CMD_SPIN, 12'sd1024);
    send_cmd(CMD_TICK, 12'sd0);
    send_cmd(CMD_TICK, 12'sd0);
    send_cmd(CMD_SPIN, 12'h7FF);
    send_cmd(CMD_TICK, 12'sd0);
    send_cmd(CMD_SPIN, 12'h800);
    send_cmd(CMD_TICK, 12'sd0);
    send_cmd(CMD_SPIN, 12'sd1023);
    send_cmd(CMD_SPIN, 12'sd1025);
    send_cmd(CMD_SPIN, 12'sd512);
    send_cmd(CMD_SPIN, -12'sd1);
    send_cmd(CMD_SPIN_DOWN, 12'sd0);
    send_cmd(CMD_TICK, 12'sd0);
    send_cmd(CMD_CUTOFF, 12'sd0);
    send_cmd(CMD_RSVD_7, 12'hFFF);
    send_cmd(CMD_DISARM, 12'sd0);
  endtask

  task automatic test_timeout_spindown();
    set_config(1000, 2000, 4095, 2);
    send_cmd(CMD_ARM, 12'sd0);
    send_cmd(CMD_SPIN, 12'sd1024);
    repeat (4) send_cmd(CMD_TICK, 12'sd0);
    send_cmd(CMD_SPIN, 12'sd700);
    send_cmd(CMD_TICK, 12'sd0);
    // Zero timeout: the first tick already drops the target
    set_config(1000, 2000, 4095, 0);
    send_cmd(CMD_SPIN, 12'sd1024);
    send_cmd(CMD_TICK, 12'sd0);
    send_cmd(CMD_DISARM, 12'sd0);
  endtask

  task automatic test_tick_saturation();
    // Full band, largest timeout: the width runs to the top and holds through a long tick run
    set_config(0, 4095, 4095, 65535);
    send_cmd(CMD_ARM, 12'sd0);
    send_cmd(CMD_SPIN, 12'sd1024);
    repeat (SAT_TICKS) send_cmd(CMD_TICK, 12'sd0);
    send_cmd(CMD_SPIN_DOWN, 12'sd0);
    send_cmd(CMD_TICK, 12'sd0);
  endtask

  task automatic pick_setting(int idx);
    case (idx)
      0: set_config(RST_PWM_MIN, RST_PWM_MAX, RST_SLEW_STEP, RST_TIMEOUT);
      1: set_config(0, 4095, 1, 0);
      2: set_config(4095, 0, 4095, 65535);
      3: set_config(1000, 2000, 0, 20);
      4: set_config(0, 4095, 4095, 5);
      5: set_config(3000, 1000, 200, 10);
      6: set_config(100, 4095, 37, 1);
      default: set_config($urandom_range(3000), $urandom_range(4095), $urandom_range(1, 600),
                          $urandom_range(0, 60));
    endcase
  endtask

  task automatic send_random_cmd();
    logic [2:0] cmd;
    logic signed [11:0] power;
    int roll;
    roll = $urandom_range(99);
    if (!armed_q && roll < 60) cmd = CMD_ARM;
    else if (roll < 40) cmd = CMD_TICK;
    else if (roll < 65) cmd = CMD_SPIN;
    else if (roll < 73) cmd = CMD_SPIN_DOWN;
    else if (roll < 79) cmd = CMD_CUTOFF;
    else if (roll < 85) cmd = CMD_DISARM;
    else if (roll < 92) cmd = CMD_ARM;
    else cmd = 3'($urandom_range(7));
    case ($urandom_range(3))
      0, 1: power = 12'($urandom_range(FULL_POWER));
      2: power = 12'($urandom());
      default: power = $urandom_range(1) ? 12'h7FF : 12'h800;
    endcase
    send_cmd(cmd, power);
  endtask

  task automatic test_random_mix();
    int sent;
    int burst;
    for (int mode = 0; mode < 3; mode++) begin
      in_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 60 : 0;
      out_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 14 : 0;
      for (int k = 0; k < 4; k++) begin
        pick_setting(mode * 4 + k);
        sent = 0;
        while (sent < PHASE_ITEMS) begin
          // Runs of ticks that can reach the timeout when it is under 100
          if (armed_q && $urandom_range(99) < 25) begin
            burst = $urandom_range(1, (timeout_ticks < 100) ? int'(timeout_ticks) + 3 : 20);
            repeat (burst) send_cmd(CMD_TICK, 12'($urandom()));
            sent += burst;
          end else begin
            send_random_cmd();
            sent++;
          end
        end
      end
    end
  endtask

  // Receiver stall and watchdog
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin : check_results
    pwm_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_failure($sformatf("transaction with nothing expected, data %h", out_tdata));
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[11:0] !== want.width || out_tdata[12] !== want.armed)
          report_failure($sformatf("width exp %0d got %0d, armed exp %0b got %0b",
                                   want.width, out_tdata[11:0], want.armed, out_tdata[12]));
      end
    end
  end

  initial begin
    apply_reset();
    test_directed_commands();
    test_timeout_spindown();
    test_tick_saturation();
    test_random_mix();
    wait_drained();
    repeat (5) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
